// ===== hw/rtl/nkl_pkg.sv =====
// Shared types and constants for the nearest keyframe lookup.
// Used by nkl_alu, nkl_seq and the top level; depends on nothing.
package nkl_pkg;

  localparam int unsigned NKL_MAX_FRAMES = 1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SPEED_W = 24;  // Q8.16 speed factor
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned MAG_W   = 33;  // |query - offset|
  localparam int unsigned ALU_W   = MAG_W + SPEED_W;  // full product width
  localparam int unsigned TIME_W  = ALU_W - FRAC_W;   // scaled time magnitude
  localparam int unsigned STAMP_W = 31;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned REP_W   = 32;
  localparam int unsigned CNT_W   = $clog2(TIME_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_OFFSET = 3'd0,
    REG_SPEED_SCALE = 3'd1,
    REG_LOOP_ON     = 3'd2,
    REG_FRAME_COUNT = 3'd3,
    REG_AUDIO_ON    = 3'd4
  } nkl_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } nkl_op_e;

  typedef struct packed {
    nkl_op_e              op;
    logic [9:0]           entry_index;
    logic [STAMP_W-1:0]   entry_time;
    logic signed [31:0]   query_time;
  } nkl_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               found;
    logic               restart_audio;
  } nkl_out_t;

  typedef struct packed {
    logic signed [31:0]   time_offset;
    logic [SPEED_W-1:0]   speed_scale;
    logic                 loop_on;
    logic [COUNT_W-1:0]   frame_count;
    logic                 audio_on;
  } nkl_cfg_t;

  // Operands for the shared adder/subtractor.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } nkl_alu_req_t;

  // carry is high on a subtract when a >= b (no borrow).
  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } nkl_alu_rsp_t;

endpackage

// ===== hw/rtl/nkl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module nkl_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/nkl_alu.sv =====
// Shared wide adder/subtractor for the offset, scaling, modulo, repetition, search and midpoint steps of a query.
// Depends on nkl_pkg for the request/response structs.
module nkl_alu (
  input  nkl_pkg::nkl_alu_req_t req_i,
  output nkl_pkg::nkl_alu_rsp_t rsp_o
);
  import nkl_pkg::*;

  logic [ALU_W-1:0] b_x;
  logic [ALU_W:0]   total;

  assign b_x   = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_x} + (ALU_W+1)'(req_i.sub);

  assign rsp_o.sum   = total[ALU_W-1:0];
  assign rsp_o.carry = total[ALU_W];

endmodule

// ===== hw/rtl/nkl_seq.sv =====
// Query sequencer: offset, shift-add scaling, restoring modulo, repetition check, table walk, nearer-neighbor pick.
// Depends on nkl_pkg; drives the shared nkl_alu and the table RAM read port.
module nkl_seq #(
  parameter int unsigned MAX_FRAMES = nkl_pkg::NKL_MAX_FRAMES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  nkl_pkg::nkl_in_t                item_i,
  output logic                            busy_o,
  input  nkl_pkg::nkl_cfg_t               cfg_i,
  output nkl_pkg::nkl_alu_req_t           alu_req_o,
  input  nkl_pkg::nkl_alu_rsp_t           alu_rsp_i,
  output logic [$clog2(MAX_FRAMES)-1:0]   rd_addr_o,
  input  logic [nkl_pkg::STAMP_W-1:0]     rd_data_i,
  output logic                            result_valid_o,
  output nkl_pkg::nkl_out_t               result_o
);
  import nkl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_ABS, S_MUL, S_DIV, S_REP,
    S_SETUP, S_WAIT, S_SRCH, S_SUM, S_MID
  } state_e;

  state_e               state_q;
  logic signed [31:0]   qry_q;
  logic                 sign_q;
  logic [ALU_W-1:0]     acc_q;
  logic [MAG_W-1:0]     mcand_q;
  logic [SPEED_W-1:0]   spd_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [STAMP_W-1:0]   last_q;
  logic [TIME_W-1:0]    quo_q;
  logic [STAMP_W-1:0]   rem_q;
  logic [TIME_W-1:0]    tval_q;
  logic [REP_W-1:0]     rep_q;
  logic                 pulse_q;
  logic [AW-1:0]        rd_addr_q;
  logic [AW-1:0]        idx_q;
  logic [STAMP_W-1:0]   prev_q;
  logic [STAMP_W-1:0]   cur_q;
  logic [STAMP_W:0]     sum_q;
  logic                 res_valid_q;
  nkl_out_t             res_q;

  logic [CW-1:0]        n_w;
  logic [CW-1:0]        nm1;
  logic                 idx_last;
  logic                 accept;
  logic [TIME_W-1:0]    tmag;
  logic [STAMP_W:0]     trial;
  logic [MAG_W-1:0]     abs_val;
  logic                 done_now;
  logic [AW-1:0]        pick_idx;
  logic                 pick_found;

  // Table size in use, clamped to the storage depth.
  always_comb begin
    if (32'(cfg_i.frame_count) > 32'(MAX_FRAMES)) begin
      n_w = CW'(MAX_FRAMES);
    end else begin
      n_w = CW'(cfg_i.frame_count);
    end
  end

  assign nm1      = n_w - CW'(1);
  assign idx_last = (CW'(idx_q) == nm1);
  assign accept   = start_i && !busy_o;
  assign tmag     = alu_rsp_i.sum[ALU_W-1:FRAC_W];
  assign trial    = {rem_q, quo_q[TIME_W-1]};
  assign abs_val  = acc_q[ALU_W-1] ? alu_rsp_i.sum[MAG_W-1:0] : acc_q[MAG_W-1:0];

  // Operand select for the shared adder.
  always_comb begin
    alu_req_o = '0;
    case (state_q)
      S_DIFF: begin
        alu_req_o.a   = {{(ALU_W-32){qry_q[31]}}, qry_q};
        alu_req_o.b   = {{(ALU_W-32){cfg_i.time_offset[31]}}, cfg_i.time_offset};
        alu_req_o.sub = 1'b1;
      end
      S_ABS: begin
        alu_req_o.b   = acc_q;
        alu_req_o.sub = 1'b1;
      end
      S_MUL: begin
        alu_req_o.a = {acc_q[ALU_W-2:0], 1'b0};
        alu_req_o.b = spd_q[SPEED_W-1] ? ALU_W'(mcand_q) : '0;
      end
      S_DIV: begin
        alu_req_o.a   = ALU_W'(trial);
        alu_req_o.b   = ALU_W'(last_q);
        alu_req_o.sub = 1'b1;
      end
      S_REP: begin
        alu_req_o.a   = ALU_W'(rep_q);
        alu_req_o.b   = ALU_W'(quo_q);
        alu_req_o.sub = 1'b1;
      end
      S_SRCH: begin
        alu_req_o.a   = ALU_W'(rd_data_i);
        alu_req_o.b   = ALU_W'(tval_q);
        alu_req_o.sub = 1'b1;
      end
      S_SUM: begin
        alu_req_o.a = ALU_W'(cur_q);
        alu_req_o.b = ALU_W'(prev_q);
      end
      S_MID: begin
        // t - prev < cur - t  <=>  2t < cur + prev
        alu_req_o.a   = ALU_W'({tval_q, 1'b0});
        alu_req_o.b   = ALU_W'(sum_q);
        alu_req_o.sub = 1'b1;
      end
      default: begin
        alu_req_o = '0;
      end
    endcase
  end

  // Finishing conditions and the chosen frame.
  always_comb begin
    done_now   = 1'b0;
    pick_idx   = '0;
    pick_found = 1'b0;
    case (state_q)
      S_SETUP: begin
        if (n_w == '0) begin
          done_now = 1'b1;
        end else if (sign_q && (tval_q != '0)) begin
          done_now   = 1'b1;
          pick_found = 1'b1;
        end
      end
      S_SRCH: begin
        if (alu_rsp_i.carry && (idx_q == '0)) begin
          done_now   = 1'b1;
          pick_found = 1'b1;
        end else if (!alu_rsp_i.carry && idx_last) begin
          done_now = 1'b1;
        end
      end
      S_MID: begin
        done_now   = 1'b1;
        pick_found = 1'b1;
        pick_idx   = alu_rsp_i.carry ? idx_q : idx_q - AW'(1);
      end
      default: begin
        done_now = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rep_q       <= '0;
      pulse_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= done_now;
      case (state_q)
        S_IDLE: begin
          if (accept && (item_i.op == OP_QUERY)) begin
            qry_q     <= item_i.query_time;
            pulse_q   <= 1'b0;
            rd_addr_q <= nm1[AW-1:0];  // last entry, needed for the wrap
            state_q   <= S_DIFF;
          end
        end
        S_DIFF: begin
          acc_q   <= alu_rsp_i.sum;
          state_q <= S_ABS;
        end
        S_ABS: begin
          sign_q  <= acc_q[ALU_W-1];
          mcand_q <= abs_val;
          acc_q   <= '0;
          spd_q   <= cfg_i.speed_scale;
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= alu_rsp_i.sum;
          spd_q <= {spd_q[SPEED_W-2:0], 1'b0};
          if (cnt_q == CNT_W'(SPEED_W - 1)) begin
            last_q <= rd_data_i;
            cnt_q  <= '0;
            if (cfg_i.loop_on && (n_w != '0) && (rd_data_i != '0)) begin
              quo_q   <= tmag;
              rem_q   <= '0;
              state_q <= S_DIV;
            end else begin
              tval_q  <= tmag;
              state_q <= S_SETUP;
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DIV: begin
          rem_q <= alu_rsp_i.carry ? alu_rsp_i.sum[STAMP_W-1:0] : trial[STAMP_W-1:0];
          quo_q <= {quo_q[TIME_W-2:0], alu_rsp_i.carry};
          if (cnt_q == CNT_W'(TIME_W - 1)) begin
            cnt_q   <= '0;
            state_q <= S_REP;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_REP: begin
          tval_q <= TIME_W'(rem_q);
          // borrow means quotient > count; negative times never count
          if (!sign_q && !alu_rsp_i.carry && (rep_q != '1)) begin
            rep_q   <= rep_q + REP_W'(1);
            pulse_q <= cfg_i.audio_on;
          end
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          rd_addr_q <= '0;
          idx_q     <= '0;
          if (!done_now) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          rd_addr_q <= rd_addr_q + AW'(1);
          state_q   <= S_SRCH;
        end
        S_SRCH: begin
          if (alu_rsp_i.carry) begin
            cur_q <= rd_data_i;
            if (!done_now) begin
              state_q <= S_SUM;
            end
          end else begin
            prev_q    <= rd_data_i;
            idx_q     <= idx_q + AW'(1);
            rd_addr_q <= rd_addr_q + AW'(1);
          end
        end
        S_SUM: begin
          sum_q   <= alu_rsp_i.sum[STAMP_W:0];
          state_q <= S_MID;
        end
        S_MID: begin
          // result word and return to idle are handled below
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (done_now) begin
        res_q.frame_index   <= FRAME_W'(pick_idx);
        res_q.found         <= pick_found;
        res_q.restart_audio <= pulse_q;
        state_q             <= S_IDLE;
      end
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign rd_addr_o      = rd_addr_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result word presented while a query is still running");

  a_rep_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_q != $past(rep_q)) |-> (rep_q == $past(rep_q) + REP_W'(1)))
    else $error("repetition count moved by other than one");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (CW'(idx_q) < n_w))
    else $error("table walk past the valid entries");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.op == OP_QUERY)) |=> (state_q == S_DIFF))
    else $error("accepted query did not start the sequence");

  a_pulse_needs_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.restart_audio) |-> cfg_i.audio_on)
    else $error("audio restart flagged with audio off");

endmodule

// ===== hw/rtl/nearest_keyframe_lookup.sv =====
// Top level of the nearest keyframe lookup: config registers, table RAM,
// shared adder and query sequencer. Depends on nkl_pkg, nkl_ram, nkl_alu, nkl_seq.
//
// A load word (op = load) writes one timestamp into the table in the cycle it
// is taken and produces no result; the block stays ready. A query word runs a
// sequence of steps on one shared 57-bit adder: offset and magnitude, the
// shift-add speed scaling, the restoring modulo and repetition check when
// looping, setup, then a walk through the table entries over the single RAM
// read port, and the pick of the nearer neighbor; it may end early at setup or
// in the walk. Busy is high throughout. The result word is shown on result_o for
// exactly one cycle with result_valid_o high; the receiver cannot hold it off,
// and the block is ready again in that same cycle. Configuration writes take
// effect at once and must only be made while busy is low. The table has no
// reset; entries are expected to be loaded before a query reads them.
module nearest_keyframe_lookup #(
  parameter int unsigned MAX_FRAMES = nkl_pkg::NKL_MAX_FRAMES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  nkl_pkg::nkl_in_t              item_i,
  // result side
  output logic                          result_valid_o,
  output nkl_pkg::nkl_out_t             result_o,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [nkl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nkl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nkl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAMES);

  nkl_cfg_t        cfg_q;
  nkl_alu_req_t    alu_req;
  nkl_alu_rsp_t    alu_rsp;
  logic [AW-1:0]   rd_addr;
  logic [STAMP_W-1:0] rd_data;
  logic            tbl_we;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_offset <= '0;
      cfg_q.speed_scale <= SPEED_W'(1 << FRAC_W);  // 1.0
      cfg_q.loop_on     <= 1'b0;
      cfg_q.frame_count <= COUNT_W'(1);
      cfg_q.audio_on    <= 1'b0;
    end else if (cfg_we_i) begin
      case (nkl_reg_e'(cfg_idx_i))
        REG_TIME_OFFSET: cfg_q.time_offset <= signed'(cfg_data_i);
        REG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data_i[SPEED_W-1:0];
        REG_LOOP_ON:     cfg_q.loop_on     <= cfg_data_i[0];
        REG_FRAME_COUNT: cfg_q.frame_count <= cfg_data_i[COUNT_W-1:0];
        REG_AUDIO_ON:    cfg_q.audio_on    <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Loads beyond the table depth are ignored.
  assign tbl_we = start && !busy && (item_i.op == OP_LOAD) &&
                  (32'(item_i.entry_index) < 32'(MAX_FRAMES));

  nkl_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_addr_i (AW'(item_i.entry_index)),
    .wr_data_i (item_i.entry_time),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nkl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  nkl_seq #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .item_i         (item_i),
    .busy_o         (busy),
    .cfg_i          (cfg_q),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
